// ===== rtl/rcgb_pkg.sv =====
`default_nettype none
package rcgb_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_PAINT_COLOR    = 3'd0,
		CFG_ORIGIN_X       = 3'd1,
		CFG_ORIGIN_Y       = 3'd2,
		CFG_SURFACE_WIDTH  = 3'd3,
		CFG_SURFACE_HEIGHT = 3'd4
	} cfg_index_t;

	// Result kinds
	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_END   = 1'b1
	} kind_t;

	localparam int unsigned CTRL_COUNT_W = 3;
	localparam int unsigned CTRL_SKIP_LSB = 3;
	localparam int unsigned CTRL_SKIP_MSB = 6;
	localparam int unsigned CTRL_EOL_BIT = 7;

	typedef struct packed {
		logic [7:0]  stream_byte;
		logic [23:0] dest_pixel;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [23:0] pixel_value;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/rcgb_blend.sv =====
`default_nettype none
module rcgb_blend
	import rcgb_pkg::*;
(
	input  wire logic [7:0]  coverage,
	input  wire logic [23:0] dest_pixel,
	input  wire logic [23:0] paint_color,
	output logic      [23:0] pixel_value
);

	logic [8:0] alpha;

	// Stretch coverage to 0..256
	assign alpha = {1'b0, coverage} + {8'd0, coverage[7]};

	// Move each channel towards the paint colour, flooring the signed step
	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [7:0]  old_c;
		logic [7:0]  paint_c;
		logic        up;
		logic [7:0]  diff;
		logic [16:0] prod;
		logic [16:0] prod_rnd;
		logic [7:0]  step;

		assign old_c    = dest_pixel[c*8 +: 8];
		assign paint_c  = paint_color[c*8 +: 8];
		assign up       = paint_c >= old_c;
		assign diff     = up ? (paint_c - old_c) : (old_c - paint_c);
		assign prod     = alpha * {1'b0, diff};
		assign prod_rnd = up ? prod : (prod + 17'd255);
		assign step     = prod_rnd[15:8];
		assign pixel_value[c*8 +: 8] = up ? (old_c + step) : (old_c - step);
	end

endmodule
`default_nettype wire

// ===== rtl/rle_coverage_glyph_blender.sv =====
`default_nettype none
// Run-length coverage glyph blender. One stream byte is taken per clock while
// the output register is free or draining; the result of a literal (or the end
// of glyph mark) appears in the output register on the cycle after its byte is
// accepted. Other control bytes and dropped literals give no result. Throughput
// is set by the output register alone: in_stall rises only while a held result
// is stalled downstream. Configuration is to be written through cfg_we/
// cfg_index/cfg_data only while idle; the block does not enforce this.
module rle_coverage_glyph_blender
	import rcgb_pkg::*;
#(
	parameter int unsigned GLYPH_WIDTH  = 6,
	parameter int unsigned GLYPH_HEIGHT = 11
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_data
);

	localparam logic [7:0]  GW8  = 8'(GLYPH_WIDTH);
	localparam logic [7:0]  GH8  = 8'(GLYPH_HEIGHT);
	localparam logic [14:0] GW15 = 15'(GLYPH_WIDTH);
	localparam logic [14:0] GH15 = 15'(GLYPH_HEIGHT);

	logic [23:0] paint_color_q;
	logic [12:0] origin_x_q;
	logic [12:0] origin_y_q;
	logic [12:0] surface_width_q;
	logic [12:0] surface_height_q;

	logic [CTRL_COUNT_W-1:0] literals_left_q;
	logic                    line_end_pending_q;
	logic [7:0]              cursor_col_q;
	logic [7:0]              cursor_row_q;

	logic        out_valid_q;
	out_item_t   out_data_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paint_color_q    <= '0;
			origin_x_q       <= '0;
			origin_y_q       <= '0;
			surface_width_q  <= '0;
			surface_height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PAINT_COLOR:    paint_color_q    <= cfg_data;
				CFG_ORIGIN_X:       origin_x_q       <= cfg_data[12:0];
				CFG_ORIGIN_Y:       origin_y_q       <= cfg_data[12:0];
				CFG_SURFACE_WIDTH:  surface_width_q  <= cfg_data[12:0];
				CFG_SURFACE_HEIGHT: surface_height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Box containment against the surface
	logic signed [14:0] ox_ext;
	logic signed [14:0] oy_ext;
	logic               box_fits;

	assign ox_ext   = 15'(signed'(origin_x_q));
	assign oy_ext   = 15'(signed'(origin_y_q));
	assign box_fits = !origin_x_q[12] && !origin_y_q[12]
		&& (ox_ext + signed'(GW15) <= signed'({2'b00, surface_width_q}))
		&& (oy_ext + signed'(GH15) <= signed'({2'b00, surface_height_q}));

	// Blend datapath
	logic [23:0] blended;

	rcgb_blend u_blend (
		.coverage    (in_data.stream_byte),
		.dest_pixel  (in_data.dest_pixel),
		.paint_color (paint_color_q),
		.pixel_value (blended)
	);

	logic accept;
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Decode the byte and work out next cursor state and result
	logic                    is_ctrl;
	logic                    is_end;
	logic [CTRL_COUNT_W-1:0] lit_next;
	logic                    pend_next;
	logic [7:0]              col_next;
	logic [7:0]              row_next;
	logic                    emit;
	out_item_t               res;

	always_comb begin
		is_ctrl   = literals_left_q == '0;
		is_end    = is_ctrl && (in_data.stream_byte == 8'd0);
		lit_next  = literals_left_q;
		pend_next = line_end_pending_q;
		col_next  = cursor_col_q;
		row_next  = cursor_row_q;
		emit      = 1'b0;
		res.kind        = KIND_PIXEL;
		res.pixel_x     = 12'(origin_x_q) + {4'd0, cursor_col_q};
		res.pixel_y     = 12'(origin_y_q) + {4'd0, cursor_row_q};
		res.pixel_value = blended;
		if (is_end) begin
			col_next  = '0;
			row_next  = '0;
			pend_next = 1'b0;
			emit      = 1'b1;
			res.kind        = KIND_END;
			res.pixel_x     = '0;
			res.pixel_y     = '0;
			res.pixel_value = '0;
		end else if (is_ctrl) begin
			col_next  = cursor_col_q
				+ {4'd0, in_data.stream_byte[CTRL_SKIP_MSB:CTRL_SKIP_LSB]};
			lit_next  = in_data.stream_byte[CTRL_COUNT_W-1:0];
			pend_next = in_data.stream_byte[CTRL_EOL_BIT];
			if (lit_next == '0 && pend_next) begin
				pend_next = 1'b0;
				col_next  = '0;
				row_next  = cursor_row_q + 8'd1;
			end
		end else begin
			emit      = box_fits && (cursor_col_q < GW8) && (cursor_row_q < GH8);
			col_next  = cursor_col_q + 8'd1;
			lit_next  = literals_left_q - 1'b1;
			if (lit_next == '0 && pend_next) begin
				pend_next = 1'b0;
				col_next  = '0;
				row_next  = cursor_row_q + 8'd1;
			end
		end
	end

	// Advance cursor state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			literals_left_q    <= '0;
			line_end_pending_q <= 1'b0;
			cursor_col_q       <= '0;
			cursor_row_q       <= '0;
		end else if (accept) begin
			literals_left_q    <= lit_next;
			line_end_pending_q <= pend_next;
			cursor_col_q       <= col_next;
			cursor_row_q       <= row_next;
		end
	end

	// Output register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire
